// ===== hdl/sha512_byte_stream_hasher_top_defines.svh =====
// ----------------------------------------------------------------------------
// SHA-512 hasher assertion macros
// Shared concurrent assertion forms for the hasher modules.
// ----------------------------------------------------------------------------
`ifndef SHA512_BYTE_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA512_BYTE_STREAM_HASHER_TOP_DEFINES_SVH

// Implication checked on every edge out of reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/sha512_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-512 package
// Constants, command/status types and round functions.
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam int BLOCK_BYTES   = 128;
    localparam int LENGTH_OFFSET = 112;
    localparam int ROUNDS        = 80;
    localparam int WORDS         = 8;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load_iv;     // reinitialise chaining value
        logic       wr_byte;     // write wr_data at fill position
        logic [7:0] wr_data;
        logic       add_len;     // add 8 to bit counter
        logic       clr_len;     // clear counter
        logic       snap_len;    // latch counter for padding
        logic       comp_start;  // begin a compression
        logic       out_shift;   // rotate chain words for output
    } t_cmd;

    typedef struct packed {
        logic       comp_busy;
        logic       block_full;  // the next byte written completes the block
        logic [6:0] fill;
        logic [63:0] len_snap;
    } t_sts;

    localparam logic [63:0] IV [WORDS] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_K [ROUNDS] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
        64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
        64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
        64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
        64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
        64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
        64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
        64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
        64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
        64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
        64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
        64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
        64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
        64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
        64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
        64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
        64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
        64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
        64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
        64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
        64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (64 - n));
    endfunction

    function automatic logic [63:0] small_sig0(input logic [63:0] x);
        small_sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] small_sig1(input logic [63:0] x);
        small_sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic logic [63:0] big_sig0(input logic [63:0] x);
        big_sig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] big_sig1(input logic [63:0] x);
        big_sig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

endpackage

// ===== hdl/sha512_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-512 datapath
// Block buffer, bit counter, one-round-per-cycle compression, chain words.
// ----------------------------------------------------------------------------
`include "sha512_byte_stream_hasher_top_defines.svh"

module sha512_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha512_pkg::t_cmd   i_cmd,
    output sha512_pkg::t_sts   o_sts,
    output logic [63:0]        o_head
);
    import sha512_pkg::*;

    // byte buffer, captured as 16 words into a 16-word schedule window
    logic [63:0] r_wbuf [16];
    logic [63:0] r_win  [16];
    logic [6:0]  r_fill;
    logic [63:0] r_len, r_len_snap;
    logic [63:0] r_h [WORDS];
    logic [63:0] r_v [WORDS];
    logic        r_busy;
    logic [6:0]  r_round;
    logic [63:0] w_next, t1, t2, wt;

    // schedule: next window word
    assign w_next = r_win[0] + small_sig0(r_win[1]) + r_win[9] + small_sig1(r_win[14]);
    assign wt     = r_win[0];
    assign t1 = r_v[7] + big_sig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + ROUND_K[r_round] + wt;
    assign t2 = big_sig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // buffer write, fill and length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_len  <= '0;
        end else begin
            if (i_cmd.wr_byte) begin
                r_fill <= r_fill + 7'd1;
            end
            if (i_cmd.clr_len) begin
                r_len <= '0;
            end else if (i_cmd.add_len) begin
                r_len <= r_len + 64'd8;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            r_wbuf[r_fill[6:3]][8*(7-r_fill[2:0]) +: 8] <= i_cmd.wr_data;
        end
        if (i_cmd.snap_len) begin
            r_len_snap <= r_len;
        end
    end

    // compression: capture block, then one round per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
        end else if (i_cmd.comp_start) begin
            r_busy  <= 1'b1;
            r_round <= '0;
        end else if (r_busy) begin
            if (r_round == 7'(ROUNDS - 1)) begin
                r_busy <= 1'b0;
            end
            r_round <= r_round + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_iv) begin
            for (int i = 0; i < WORDS; i++) begin
                r_h[i] <= IV[i];
            end
        end else if (r_busy && r_round == 7'(ROUNDS - 1)) begin
            r_h[0] <= r_h[0] + t1 + t2;
            r_h[1] <= r_h[1] + r_v[0];
            r_h[2] <= r_h[2] + r_v[1];
            r_h[3] <= r_h[3] + r_v[2];
            r_h[4] <= r_h[4] + r_v[3] + t1;
            r_h[5] <= r_h[5] + r_v[4];
            r_h[6] <= r_h[6] + r_v[5];
            r_h[7] <= r_h[7] + r_v[6];
        end else if (i_cmd.out_shift) begin
            for (int i = 0; i < WORDS - 1; i++) begin
                r_h[i] <= r_h[i + 1];
            end
            r_h[WORDS - 1] <= r_h[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_start) begin
            // the closing byte arrives with the start command
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_wbuf[i];
            end
            r_win[15] <= {r_wbuf[15][63:8], i_cmd.wr_data};
            for (int i = 0; i < WORDS; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[15] <= w_next;
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    assign o_sts.comp_busy  = r_busy;
    assign o_sts.block_full = (r_fill == 7'(BLOCK_BYTES - 1));
    assign o_sts.fill       = r_fill;
    assign o_sts.len_snap   = r_len_snap;
    assign o_head           = r_h[0];

    `SHA_ASSERT_IMP(a_no_write_busy, i_clk, i_rst_n, r_busy, !i_cmd.wr_byte)
    `SHA_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_cmd.comp_start, r_busy)
    `SHA_ASSERT_IMP(a_round_range, i_clk, i_rst_n, r_busy, r_round < 7'(ROUNDS))

endmodule

// ===== hdl/sha512_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-512 controller
// Sequences byte writes, padding, compressions and digest output.
// ----------------------------------------------------------------------------
`include "sha512_byte_stream_hasher_top_defines.svh"

module sha512_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic [7:0]         i_data_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_last_word,
    input  sha512_pkg::t_sts   i_sts,
    output sha512_pkg::t_cmd   o_cmd
);
    import sha512_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_first, n_first;   // pad byte not yet written
    logic       r_extra, n_extra;   // current block has no room for the length
    logic       extra_blk;
    logic [7:0] pad_data;
    logic       acc;

    assign acc = i_valid && o_ready;

    // the block being padded leaves the length to a further block
    assign extra_blk = r_first ? (i_sts.fill >= 7'(LENGTH_OFFSET)) : r_extra;

    // padding byte for the current fill position
    always_comb begin
        if (r_first) begin
            pad_data = PAD_BYTE;
        end else if (!r_extra && i_sts.fill >= 7'(BLOCK_BYTES - 8)) begin
            pad_data = i_sts.len_snap[8*(7-i_sts.fill[2:0]) +: 8];
        end else begin
            pad_data = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_first <= 1'b0;
            r_extra <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_first <= n_first;
            r_extra <= n_extra;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_first = r_first;
        n_extra = r_extra;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        o_last_word = (r_cnt == 3'(WORDS - 1));
        unique case (r_state)
            S_IDLE: begin
                o_ready = !i_sts.comp_busy;
                if (acc) begin
                    if (!i_kind) begin
                        o_cmd.wr_byte = 1'b1;
                        o_cmd.wr_data = i_data_byte;
                        o_cmd.add_len = 1'b1;
                        o_cmd.comp_start = i_sts.block_full;
                    end else begin
                        o_cmd.snap_len = 1'b1;
                        n_first = 1'b1;
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (!i_sts.comp_busy) begin
                    o_cmd.wr_byte = 1'b1;
                    o_cmd.wr_data = pad_data;
                    o_cmd.comp_start = i_sts.block_full;
                    n_first = 1'b0;
                    if (r_first) begin
                        n_extra = (i_sts.fill >= 7'(LENGTH_OFFSET));
                    end
                    if (i_sts.block_full) begin
                        if (extra_blk) begin
                            n_extra = 1'b0;
                        end else begin
                            n_state = S_WAIT;
                        end
                    end
                end
            end
            S_WAIT: begin
                if (!i_sts.comp_busy) begin
                    n_cnt   = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    o_cmd.out_shift = 1'b1;
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'(WORDS - 1)) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                o_cmd.load_iv = 1'b1;
                o_cmd.clr_len = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    `SHA_ASSERT_IMP(a_out_only_out, i_clk, i_rst_n, o_valid, r_state == S_OUT)
    `SHA_ASSERT_IMP(a_fill_clear, i_clk, i_rst_n, r_state == S_OUT, i_sts.fill == '0)
    `SHA_ASSERT_IMP(a_no_start_busy, i_clk, i_rst_n, o_cmd.comp_start, !i_sts.comp_busy)

endmodule

// ===== hdl/sha512_byte_stream_hasher_top.sv =====
// Input: each accepted byte is written to the block buffer; the byte that completes a block starts an
// 80-round compression, one round per cycle, during which no byte is taken.
// Finish: padding bytes complete the message, compressing one or two blocks; the controller
// then waits for the last compression, outputs 8 digest words and reinitialises.
// The shared round unit sets the rate: no byte is taken while a block is compressed.
// Reset: synchronous active low; restores the initial hash, clears length and fill.
// ----------------------------------------------------------------------------
// SHA-512 byte stream hasher, top level
// Joins controller and datapath; one byte per transaction in, digest words out.
// ----------------------------------------------------------------------------
module sha512_byte_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_word,
    output logic        o_last_word
);
    import sha512_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sha512_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_data_byte,
        .o_valid, .i_ready, .o_last_word, .i_sts(sts), .o_cmd(cmd)
    );

    sha512_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts), .o_head(o_digest_word)
    );

endmodule

// ===== tb/sha512_digest_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-512 digest checker
// Watches both channels, folds accepted bytes into a private SHA-512 state
// and compares each digest word against the oldest predicted word.
// ----------------------------------------------------------------------------
module sha512_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_digest_word,
    input  logic        i_last_word,
    output int          o_errors,
    output int          o_pending
);
    import sha512_pkg::*;

    typedef struct packed {
        logic [63:0] word;
        logic        last;
    } t_digest_item;

    t_digest_item digest_q[$];
    logic [63:0]  hash_state [WORDS];
    logic [63:0]  msg_bits;
    logic [7:0]   blk_buf [BLOCK_BYTES];
    int           blk_fill;

    function automatic logic [63:0] ror64(input logic [63:0] v, input int n);
        return (v >> n) | (v << (64 - n));
    endfunction

    // Fold the full buffer into the chaining words
    task automatic fold_block();
        logic [63:0] w [80];
        logic [63:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++) begin
            w[t] = '0;
            for (int i = 0; i < 8; i++) w[t] = {w[t][55:0], blk_buf[t*8+i]};
        end
        for (int t = 16; t < 80; t++) begin
            w[t] = w[t-16] + w[t-7]
                 + (ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7))
                 + (ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6));
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int t = 0; t < 80; t++) begin
            t1 = h + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41))
               + ((e & f) ^ (~e & g)) + ROUND_K[t] + w[t];
            t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39))
               + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic append_byte(input logic [7:0] v);
        blk_buf[blk_fill] = v;
        blk_fill++;
        if (blk_fill == BLOCK_BYTES) begin
            fold_block();
            blk_fill = 0;
        end
    endtask

    task automatic restart_message();
        for (int i = 0; i < WORDS; i++) hash_state[i] = IV[i];
        msg_bits = '0;
        blk_fill = 0;
    endtask

    // Pad, emit the eight chaining words and restart
    task automatic close_message();
        logic [63:0] len;
        len = msg_bits;
        append_byte(PAD_BYTE);
        while (blk_fill != LENGTH_OFFSET) append_byte(8'h00);
        for (int i = 0; i < 8; i++) append_byte(8'h00);
        for (int i = 0; i < 8; i++) append_byte(len[63-8*i -: 8]);
        for (int i = 0; i < WORDS; i++) digest_q.push_back('{hash_state[i], i == WORDS-1});
        restart_message();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("checker: %s mismatch got %h want %h", what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        restart_message();
    end

    assign o_pending = digest_q.size();

    // Track input transactions and check output transactions
    always @(posedge i_clk) begin
        t_digest_item exp_item;
        if (!i_rst_n) begin
            restart_message();
            digest_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (digest_q.size() == 0) begin
                    report_mismatch("unexpected word", i_digest_word, '0);
                end else begin
                    exp_item = digest_q.pop_front();
                    if (i_digest_word !== exp_item.word)
                        report_mismatch("digest word", i_digest_word, exp_item.word);
                    if (i_last_word !== exp_item.last)
                        report_mismatch("last flag", i_last_word, exp_item.last);
                end
            end
            if (i_valid && i_ready) begin
                if (i_kind) close_message();
                else begin
                    append_byte(i_data_byte);
                    msg_bits += 64'd8;
                end
            end
        end
    end
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// SHA-512 byte stream hasher testbench
// Drives directed and random messages with random gaps and back-pressure;
// the checker predicts every digest and the top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_kind = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_digest_word;
    logic        o_last_word;
    int          err_count;
    int          words_pending;
    bit          calm_sink = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sha512_byte_stream_hasher_top dut (.*);

    sha512_digest_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_ready(o_ready), .i_kind, .i_data_byte,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_digest_word(o_digest_word),
        .i_last_word(o_last_word), .o_errors(err_count), .o_pending(words_pending)
    );

    // Back-pressure on the digest side
    always @(posedge i_clk) begin
        i_ready <= calm_sink || ($urandom_range(0, 99) >= 15);
    end

    // Offer one transaction, with an optional random gap first; valid stays up after it
    task automatic send_item(input logic kind, input logic [7:0] b, input bit gaps);
        while (gaps && $urandom_range(0, 99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_message(input int len, input bit gaps);
        for (int i = 0; i < len; i++) send_item(1'b0, 8'($urandom), gaps);
        send_item(1'b1, 8'($urandom), gaps);
    endtask

    initial begin
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: empty message, extreme bytes, ignored byte on finish
        send_item(1'b1, 8'hff, 1'b1);
        send_item(1'b0, 8'h00, 1'b1);
        send_item(1'b0, 8'hff, 1'b1);
        send_item(1'b1, 8'h00, 1'b1);
        for (int i = 0; i < 3; i++) send_item(1'b0, 8'h61 + 8'(i), 1'b1);
        send_item(1'b1, 8'ha5, 1'b1);
        i_valid <= 1'b0;
        // Hold off until every digest has arrived
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        // Random: mostly short messages, some around and over a block
        n = 0;
        while (n < 230) begin
            int len;
            case ($urandom_range(0, 9))
                0: len = 0;
                1: len = $urandom_range(110, 140);
                2: len = $urandom_range(240, 260);
                default: len = $urandom_range(1, 30);
            endcase
            if (n + len + 1 > 230) len = 230 - n - 1;
            send_message(len, !(n > 100 && n < 160));
            calm_sink = (n > 100 && n < 160);
            n += len + 1;
        end
        i_valid <= 1'b0;
        calm_sink = 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (err_count == 0 && words_pending == 0) $display("testbench: done, clean");
        else $display("testbench: done, errors");
        $finish;
    end

    initial begin
        #5000000;
        $display("testbench: done, errors");
        $finish;
    end
endmodule
